@@ rtl/core/irlm_pkg.sv @@
// ---------------------------------------------------------------------------
// irlm_pkg
// Types, codes and reset values for the IR learning lamp mode controller.
// ---------------------------------------------------------------------------
package irlm_pkg;

   localparam int unsigned CODE_W     = 32;
   localparam int unsigned CSR_DATA_W = 8;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned MODE_W     = 3;
   localparam int unsigned LEARNED_W  = 2;
   localparam int unsigned LAMP_W     = 4;

   localparam logic [7:0] SHORT_PRESS_MIN_RST     = 8'd2;
   localparam logic [7:0] SHORT_PRESS_LIMIT_RST   = 8'd50;
   localparam logic [7:0] LONG_PRESS_MIN_RST      = 8'd51;
   localparam logic [7:0] BLINK_PERIOD_RST        = 8'h06;
   localparam logic [7:0] RECORD_BLINK_PERIOD_RST = 8'h03;
   localparam logic [7:0] PRESS_SAT               = 8'hFF;
   localparam logic [CODE_W-1:0] ERASED_CODE      = '1;

   // lamp vector bit positions
   localparam int unsigned LAMP_GM = 0;
   localparam int unsigned LAMP_GB = 1;
   localparam int unsigned LAMP_RM = 2;
   localparam int unsigned LAMP_RB = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SHORT_PRESS_MIN     = 3'd0,
      CSR_SHORT_PRESS_LIMIT   = 3'd1,
      CSR_LONG_PRESS_MIN      = 3'd2,
      CSR_BLINK_PERIOD        = 3'd3,
      CSR_RECORD_BLINK_PERIOD = 3'd4
   } csr_index_type;

   typedef enum logic [4:0] {
      S_OFF       = 5'b00001,
      S_GREEN     = 5'b00010,
      S_RED       = 5'b00100,
      S_REC_GREEN = 5'b01000,
      S_REC_RED   = 5'b10000
   } mode_type;

   localparam logic [MODE_W-1:0] MODE_CODE_OFF       = 3'd0;
   localparam logic [MODE_W-1:0] MODE_CODE_GREEN     = 3'd1;
   localparam logic [MODE_W-1:0] MODE_CODE_RED       = 3'd2;
   localparam logic [MODE_W-1:0] MODE_CODE_REC_GREEN = 3'd3;
   localparam logic [MODE_W-1:0] MODE_CODE_REC_RED   = 3'd4;

   localparam logic [LEARNED_W-1:0] LEARNED_NONE  = 2'd0;
   localparam logic [LEARNED_W-1:0] LEARNED_GREEN = 2'd1;
   localparam logic [LEARNED_W-1:0] LEARNED_RED   = 2'd2;

   function automatic logic [MODE_W-1:0] mode_code(input mode_type m);
      logic [MODE_W-1:0] c;
      case (m)
         S_GREEN:     c = MODE_CODE_GREEN;
         S_RED:       c = MODE_CODE_RED;
         S_REC_GREEN: c = MODE_CODE_REC_GREEN;
         S_REC_RED:   c = MODE_CODE_REC_RED;
         default:     c = MODE_CODE_OFF;
      endcase
      return c;
   endfunction

endpackage

@@ rtl/core/irlm_req_if.sv @@
// ---------------------------------------------------------------------------
// irlm_req_if
// Input word channel: tick or IR code, with valid/ready handshake.
// ---------------------------------------------------------------------------
interface irlm_req_if;
   import irlm_pkg::*;

   logic              valid;
   logic              ready;
   logic              command;
   logic              button_pressed;
   logic [CODE_W-1:0] ir_code;
   logic              ir_is_repeat;

   modport source (output valid, command, button_pressed, ir_code, ir_is_repeat,
                   input ready);
   modport sink   (input valid, command, button_pressed, ir_code, ir_is_repeat,
                   output ready);
endinterface

@@ rtl/core/irlm_rsp_if.sv @@
// ---------------------------------------------------------------------------
// irlm_rsp_if
// Result word channel: mode, lamp levels and learn status.
// ---------------------------------------------------------------------------
interface irlm_rsp_if;
   import irlm_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [MODE_W-1:0]    mode;
   logic                 green_main;
   logic                 green_back;
   logic                 red_main;
   logic                 red_back;
   logic [LEARNED_W-1:0] learned;

   modport source (output valid, mode, green_main, green_back, red_main, red_back,
                   learned, input ready);
   modport sink   (input valid, mode, green_main, green_back, red_main, red_back,
                   learned, output ready);
endinterface

@@ rtl/core/ir_learning_lamp_mode_controller_top.sv @@
// A word's result is registered and is valid from the edge at which the word is accepted.
// Throughput: one word per cycle; the input is taken whenever the result register is
// empty or is being read in the same cycle.
// Reset (synchronous): green mode, lamps off, counters zero, code stores erased
// to all ones, registers at their default values.
// ---------------------------------------------------------------------------
// ir_learning_lamp_mode_controller_top
// Five-mode lamp controller: button press timing, lamp blinking and IR code
// matching/learning, one word per cycle into a single result register while it is free or read.
// ---------------------------------------------------------------------------
module ir_learning_lamp_mode_controller_top (
   input  logic                                clock,
   input  logic                                reset,
   irlm_req_if.sink                            req_ch,
   irlm_rsp_if.source                          rsp_ch,
   input  logic                                csr_wr_en,
   input  logic [irlm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [irlm_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import irlm_pkg::*;

   logic [7:0] short_min_ff, short_limit_ff, long_min_ff, blink_per_ff, rec_per_ff;

   mode_type          mode_ff, mode_in;
   logic [7:0]        press_ff, press_in;
   logic [7:0]        blink_ff, blink_in;
   logic [7:0]        rec_ff, rec_in;
   logic [LAMP_W-1:0] lamp_ff, lamp_in;
   logic [CODE_W-1:0] green_code_ff, green_code_in;
   logic [CODE_W-1:0] red_code_ff, red_code_in;
   logic [LEARNED_W-1:0] learned_in;

   logic                 rsp_valid_ff;
   logic [MODE_W-1:0]    rsp_mode_ff;
   logic [LAMP_W-1:0]    rsp_lamp_ff;
   logic [LEARNED_W-1:0] rsp_learned_ff;

   logic accept;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         short_min_ff   <= SHORT_PRESS_MIN_RST;
         short_limit_ff <= SHORT_PRESS_LIMIT_RST;
         long_min_ff    <= LONG_PRESS_MIN_RST;
         blink_per_ff   <= BLINK_PERIOD_RST;
         rec_per_ff     <= RECORD_BLINK_PERIOD_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_SHORT_PRESS_MIN:     short_min_ff   <= csr_wdata;
            CSR_SHORT_PRESS_LIMIT:   short_limit_ff <= csr_wdata;
            CSR_LONG_PRESS_MIN:      long_min_ff    <= csr_wdata;
            CSR_BLINK_PERIOD:        blink_per_ff   <= csr_wdata;
            CSR_RECORD_BLINK_PERIOD: rec_per_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // next state for one word
   always_comb begin
      mode_type          m, tgt;
      logic [LAMP_W-1:0] lamps;
      logic [7:0]        bc, rc, pt;

      m             = mode_ff;
      tgt           = mode_ff;
      lamps         = lamp_ff;
      bc            = blink_ff;
      rc            = rec_ff;
      pt            = press_ff;
      green_code_in = green_code_ff;
      red_code_in   = red_code_ff;
      learned_in    = LEARNED_NONE;

      if (!req_ch.command) begin
         if (req_ch.button_pressed) begin
            if (pt != PRESS_SAT) begin
               pt = pt + 8'd1;
            end
         end else begin
            if (pt >= short_min_ff && pt < short_limit_ff) begin
               tgt = (m == S_OFF) ? S_GREEN : S_OFF;
            end else if (pt >= long_min_ff) begin
               case (m)
                  S_REC_GREEN: tgt = S_GREEN;
                  S_REC_RED:   tgt = S_RED;
                  S_GREEN:     tgt = S_REC_GREEN;
                  S_RED:       tgt = S_REC_RED;
                  default:     tgt = m;
               endcase
            end
            pt = '0;
         end
         if (tgt != m) begin
            m     = tgt;
            lamps = '0;
         end
         if (bc == 8'd0) begin
            bc = blink_per_ff;
            if (m == S_GREEN) begin
               lamps[LAMP_GM] = !lamps[LAMP_GM];
               lamps[LAMP_GB] = !lamps[LAMP_GB];
            end else if (m == S_RED) begin
               lamps[LAMP_RM] = !lamps[LAMP_RM];
               lamps[LAMP_RB] = !lamps[LAMP_RB];
            end
         end
         if (rc == 8'd0) begin
            rc = rec_per_ff;
            if (m == S_REC_GREEN) begin
               lamps[LAMP_GB] = !lamps[LAMP_GB];
            end else if (m == S_REC_RED) begin
               lamps[LAMP_RB] = !lamps[LAMP_RB];
            end
         end
         bc = bc - 8'd1;
         rc = rc - 8'd1;
      end else if (!req_ch.ir_is_repeat) begin
         case (m)
            S_GREEN, S_RED: begin
               if (req_ch.ir_code == green_code_ff) begin
                  tgt = S_GREEN;
               end else if (req_ch.ir_code == red_code_ff) begin
                  tgt = S_RED;
               end
            end
            S_REC_GREEN: begin
               green_code_in = req_ch.ir_code;
               learned_in    = LEARNED_GREEN;
               tgt           = S_REC_RED;
            end
            S_REC_RED: begin
               if (req_ch.ir_code != green_code_ff) begin
                  red_code_in = req_ch.ir_code;
                  learned_in  = LEARNED_RED;
                  tgt         = S_GREEN;
               end
            end
            default: ;
         endcase
         if (tgt != m) begin
            m     = tgt;
            lamps = '0;
         end
      end

      mode_in  = m;
      lamp_in  = lamps;
      blink_in = bc;
      rec_in   = rc;
      press_in = pt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= S_GREEN;
         press_ff      <= '0;
         blink_ff      <= '0;
         rec_ff        <= '0;
         lamp_ff       <= '0;
         green_code_ff <= ERASED_CODE;
         red_code_ff   <= ERASED_CODE;
      end else if (accept) begin
         mode_ff       <= mode_in;
         press_ff      <= press_in;
         blink_ff      <= blink_in;
         rec_ff        <= rec_in;
         lamp_ff       <= lamp_in;
         green_code_ff <= green_code_in;
         red_code_ff   <= red_code_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_mode_ff    <= mode_code(mode_in);
         rsp_lamp_ff    <= lamp_in;
         rsp_learned_ff <= learned_in;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.mode       = rsp_mode_ff;
   assign rsp_ch.green_main = rsp_lamp_ff[LAMP_GM];
   assign rsp_ch.green_back = rsp_lamp_ff[LAMP_GB];
   assign rsp_ch.red_main   = rsp_lamp_ff[LAMP_RM];
   assign rsp_ch.red_back   = rsp_lamp_ff[LAMP_RB];
   assign rsp_ch.learned    = rsp_learned_ff;

   a_accept_gives_word: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted word produced no result");

   a_off_lamps_dark: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_mode_ff == MODE_CODE_OFF) |-> (rsp_lamp_ff == '0))
      else $error("lamp lit in off mode");

   a_rec_green_lamps: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_mode_ff == MODE_CODE_REC_GREEN)
         |-> (!rsp_lamp_ff[LAMP_GM] && !rsp_lamp_ff[LAMP_RM] && !rsp_lamp_ff[LAMP_RB]))
      else $error("wrong lamp lit while recording green");

   a_learn_green_mode: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_learned_ff == LEARNED_GREEN)
         |-> (rsp_mode_ff == MODE_CODE_REC_RED))
      else $error("green code learned without moving to record red");

   a_learn_red_mode: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_learned_ff == LEARNED_RED) |-> (rsp_mode_ff == MODE_CODE_GREEN))
      else $error("red code learned without returning to green");

endmodule
